@@ src/mi3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  // element format
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int N_ELEM    = 9;

  // stream widths
  localparam int MAT_W   = N_ELEM * ELEM_W;
  localparam int TDATA_W = ((MAT_W + 7) / 8) * 8;
  localparam int TUSER_W = 2;

  // flag positions in out_tuser
  localparam int USER_SINGULAR = 0;
  localparam int USER_SATURATED = 1;

  // internal arithmetic widths
  localparam int PROD_W = 2 * ELEM_W;
  localparam int CF_W   = 2 * ELEM_W + 1;
  localparam int PART_W = 2 * ELEM_W + 2;
  localparam int DET_W  = 3 * ELEM_W + 3;
  localparam int DIV_W  = DET_W + ELEM_W + 2;
  localparam int NUM_SH = 2 * FRAC_BITS + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [N_ELEM-1:0] mat_t;

endpackage
`default_nettype wire

@@ src/matrix_inverse_3x3_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// 3x3 matrix inverse by the adjugate, signed fixed point Q16.16
// in_*: one beat carries a whole matrix in in_tdata, nine 32-bit elements
//   row by row, row 0 column 0 in the lowest bits
// out_*: one beat per matrix, result elements in the same order in
//   out_tdata; out_tuser[0] singular, out_tuser[1] saturated
// a singular matrix (determinant exactly zero) comes back unchanged
// other matrices give the inverse rounded to nearest, clipped to range
// the pipeline has six stages for products, cofactors, determinant and
//   magnitudes, ELEM_W + 1 stages of the per-element restoring dividers,
//   and one output register
// throughput is one matrix per cycle unless the output stalls; the nine
//   divider lanes each retire one quotient bit per stage
// reset clears only the valid bits, so the pipeline comes up empty
// when out_tready is low with a beat waiting, the whole pipeline holds
//   and in_tready drops; nothing is lost or repeated
module matrix_inverse_3x3_core
  import mi3_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // rgt_x rgt_y rgt_z up_x up_y up_z fwd_x fwd_y fwd_z
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // out_rgt_x .. out_fwd_z, same order as input
  output logic [TUSER_W-1:0]      out_tuser   // singular saturated
);

  logic en;
  mat_t m0;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  mat_t m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;

  logic signed [PROD_W-1:0] pa1_r [N_ELEM];
  logic signed [PROD_W-1:0] pb1_r [N_ELEM];
  logic signed [CF_W-1:0]   cf2_r [N_ELEM];
  logic signed [CF_W-1:0]   cf3_r [N_ELEM];
  logic signed [CF_W-1:0]   cf4_r [N_ELEM];
  logic signed [CF_W-1:0]   cf5_r [N_ELEM];
  logic signed [PART_W-1:0] plo3_r [3];
  logic signed [PART_W-1:0] phi3_r [3];
  logic signed [DET_W-1:0]  term4_r [3];
  logic signed [DET_W-1:0]  det5_r;

  logic [DIV_W-1:0]  num6_r [N_ELEM];
  logic [DIV_W-1:0]  den6_r;
  logic [N_ELEM-1:0] neg6_r;
  logic              sing6_r;

  logic              sv_r   [ELEM_W+1];
  logic              ssg_r  [ELEM_W+1];
  logic [N_ELEM-1:0] sneg_r [ELEM_W+1];
  mat_t              smat_r [ELEM_W+1];

  logic [ELEM_W-1:0] quo [N_ELEM];
  logic [N_ELEM-1:0] ovf;

  logic               out_tvalid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic [TUSER_W-1:0] out_tuser_r;

  // whole pipeline moves unless a result waits on a stalled receiver
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign m0        = in_tdata[MAT_W-1:0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // matrix carried for the singular case
  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= m0;
      m2_r <= m1_r;
      m3_r <= m2_r;
      m4_r <= m3_r;
      m5_r <= m4_r;
      m6_r <= m5_r;
    end
  end

  // stages 1 and 2: minor products, then cofactors in adjugate order
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int K  = r * 3 + c;
      always_ff @(posedge clk) begin
        if (en) begin
          pa1_r[K] <= $signed(m0[C1*3+R1]) * $signed(m0[C2*3+R2]);
          pb1_r[K] <= $signed(m0[C1*3+R2]) * $signed(m0[C2*3+R1]);
          cf2_r[K] <= CF_W'(pa1_r[K]) - CF_W'(pb1_r[K]);
          cf3_r[K] <= cf2_r[K];
          cf4_r[K] <= cf3_r[K];
          cf5_r[K] <= cf4_r[K];
        end
      end
    end
  end

  // stages 3 and 4: row 0 times first adjugate column, split in halves
  for (genvar k = 0; k < 3; k++) begin : g_det
    logic [ELEM_W-1:0]        lo;
    logic signed [CF_W-ELEM_W-1:0] hi;
    assign lo = cf2_r[k*3][ELEM_W-1:0];
    assign hi = cf2_r[k*3][CF_W-1:ELEM_W];
    always_ff @(posedge clk) begin
      if (en) begin
        plo3_r[k]  <= $signed(m2_r[k]) * $signed({1'b0, lo});
        phi3_r[k]  <= $signed(m2_r[k]) * hi;
        term4_r[k] <= (DET_W'(phi3_r[k]) <<< ELEM_W) + DET_W'(plo3_r[k]);
      end
    end
  end

  // stage 5: determinant
  always_ff @(posedge clk) begin
    if (en) begin
      det5_r <= term4_r[0] + term4_r[1] + term4_r[2];
    end
  end

  // stage 6: magnitudes, rounding numerators, signs
  logic [DET_W-1:0] dmag;
  assign dmag = det5_r[DET_W-1] ? DET_W'(-det5_r) : DET_W'(det5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      den6_r  <= DIV_W'(dmag) << 1;
      sing6_r <= (det5_r == '0);
    end
  end

  for (genvar k = 0; k < N_ELEM; k++) begin : g_mag
    logic [CF_W-1:0] cmag;
    assign cmag = cf5_r[k][CF_W-1] ? CF_W'(-cf5_r[k]) : CF_W'(cf5_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        num6_r[k] <= (DIV_W'(cmag) << NUM_SH) + DIV_W'(dmag);
        neg6_r[k] <= cf5_r[k][CF_W-1] ^ det5_r[DET_W-1];
      end
    end
    mi3_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (num6_r[k]),
      .den (den6_r),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  // side data kept in step with the divider lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= ELEM_W; j++) sv_r[j] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v6_r;
      for (int j = 1; j <= ELEM_W; j++) sv_r[j] <= sv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ssg_r[0]  <= sing6_r;
      sneg_r[0] <= neg6_r;
      smat_r[0] <= m6_r;
      for (int j = 1; j <= ELEM_W; j++) begin
        ssg_r[j]  <= ssg_r[j-1];
        sneg_r[j] <= sneg_r[j-1];
        smat_r[j] <= smat_r[j-1];
      end
    end
  end

  // sign, saturation and singular select
  localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  mat_t              res_nxt;
  logic [N_ELEM-1:0] sat_nxt;

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      if (!sneg_r[ELEM_W][k]) begin
        sat_nxt[k] = ovf[k] || quo[k][ELEM_W-1];
        res_nxt[k] = sat_nxt[k] ? MAX_POS : quo[k];
      end else begin
        sat_nxt[k] = ovf[k] || (quo[k] > MIN_NEG);
        res_nxt[k] = sat_nxt[k] ? MIN_NEG : (-quo[k]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sv_r[ELEM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ssg_r[ELEM_W]) begin
        out_tdata_r <= TDATA_W'(smat_r[ELEM_W]);
        out_tuser_r[USER_SINGULAR]  <= 1'b1;
        out_tuser_r[USER_SATURATED] <= 1'b0;
      end else begin
        out_tdata_r <= TDATA_W'(res_nxt);
        out_tuser_r[USER_SINGULAR]  <= 1'b0;
        out_tuser_r[USER_SATURATED] <= |sat_nxt;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

@@ src/mi3_div_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mi3_div_lane
  import mi3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_W-1:0]  num,
  input  wire logic [DIV_W-1:0]  den,
  output logic      [ELEM_W-1:0] quo,
  output logic                   ovf
);

  logic [DIV_W-1:0]  rem_r [ELEM_W+1];
  logic [DIV_W-1:0]  den_r [ELEM_W+1];
  logic [ELEM_W-1:0] quo_r [ELEM_W+1];
  logic              ovf_r [ELEM_W+1];

  // entry stage: quotient too big for the element width
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= (num >= (den << ELEM_W));
    end
  end

  // one restoring step per stage, msb first
  for (genvar s = 0; s < ELEM_W; s++) begin : g_step
    logic [DIV_W-1:0] sub_nxt;
    logic             take_nxt;
    always_comb begin
      sub_nxt  = den_r[s] << (ELEM_W - 1 - s);
      take_nxt = (rem_r[s] >= sub_nxt);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= take_nxt ? (rem_r[s] - sub_nxt) : rem_r[s];
        den_r[s+1] <= den_r[s];
        quo_r[s+1] <= {quo_r[s][ELEM_W-2:0], take_nxt};
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  assign quo = quo_r[ELEM_W];
  assign ovf = ovf_r[ELEM_W];

endmodule
`default_nettype wire
